// File: sv/mask_alpha_composite_assert.svh
// Assertion macros shared by the mask alpha compositor RTL.
`ifndef MASK_ALPHA_COMPOSITE_ASSERT_SVH
`define MASK_ALPHA_COMPOSITE_ASSERT_SVH

// Property that must hold at every sampled edge outside reset.
`define MAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent this cycle implies consequent on the next cycle.
`define MAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/mac_pkg.sv
// Types, constants and helpers for the mask alpha compositor.
package mac_pkg;

  localparam int MAC_MAX_FRAME_DIM = 4096;
  localparam int MAC_MAX_MASK_DIM  = 256;

  localparam int MAT_AW    = 16;               // matte store address bits
  localparam int MAT_DEPTH = 1 << MAT_AW;

  localparam int FD_RW  = 13;                  // frame dimension register bits
  localparam int MD_RW  = 9;                   // matte dimension register bits
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 24;

  typedef enum logic [CFG_IW-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_MASK_WIDTH   = 3'd2,
    REG_MASK_HEIGHT  = 3'd3,
    REG_USE_BG_IMAGE = 3'd4,
    REG_SOLID_COLOR  = 3'd5,
    REG_MASK_PRESENT = 3'd6
  } cfg_reg_t;

  // Step recompute sequencer
  typedef enum logic [1:0] {
    RC_IDLE,
    RC_LOAD,
    RC_DIV
  } rc_state_t;

  // Which quotient the shared divider is working on
  typedef enum logic [1:0] {
    PH_XPOS,
    PH_XSTEP,
    PH_YPOS,
    PH_YSTEP
  } rc_phase_t;

  // Dimension register value minus one, with 0 read as 1 and clamped to max_dim.
  function automatic logic [FD_RW-1:0] dim_m1(input logic [FD_RW-1:0] v,
                                              input int unsigned max_dim);
    logic [FD_RW-1:0] res;
    res = FD_RW'(max_dim - 1);
    if (v == '0) begin
      res = '0;
    end else if (32'(v) <= max_dim) begin
      res = v - 1'b1;
    end
    return res;
  endfunction

  // floor(v / 255), exact for any v up to 255*255.
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = 17'(v) + 17'(v[15:8]) + 17'd1;
    return t[15:8];
  endfunction

endpackage

// File: sv/mask_alpha_composite.sv
// Mask alpha compositor: matte store, raster position tracking and per-channel blend.
// Composites raster-order foreground pixels over a background (the word's own
// background channels or the solid colour register) through an 8-bit matte held
// in a 64K x 8 single-port RAM. A word with in_tuser low writes one matte byte at
// mask_address and gives no output; a word with in_tuser high is a pixel and gives
// exactly one output word, out_tlast marking the last pixel of the frame. The matte
// is sampled nearest-below: the column and row sample indices are kept by two
// incremental steppers (quotient plus remainder carried per pixel), so no divide
// sits in the pixel path. Throughput is one word per clock whenever the output
// side takes its words and no recompute is running; an accepted pixel passes
// registered stages for the RAM read, the multiply, and the sum and divide by
// 255. Writing any of the four dimension registers starts a recompute of the
// stepper state on one shared restoring divider, one quotient bit per cycle over
// four divisions; in_tready is held low until the recompute is done. Matte
// writes and pixels are otherwise taken back to back and the RAM needs no
// clearing pass: sampling an entry never written returns whatever the RAM holds.
`include "mask_alpha_composite_assert.svh"

module mask_alpha_composite #(
  parameter int MAX_FRAME_DIM = mac_pkg::MAC_MAX_FRAME_DIM,
  parameter int MAX_MASK_DIM  = mac_pkg::MAC_MAX_MASK_DIM
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // mask_address, mask_value, fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue
  input  logic [71:0]                 in_tdata,
  // kind
  input  logic                        in_tuser,
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // out_red, out_green, out_blue
  output logic [23:0]                 out_tdata,
  output logic                        out_tlast,
  // configuration writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mac_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [mac_pkg::CFG_DW-1:0]  cfg_data
);
  import mac_pkg::*;

  localparam int CW  = $clog2(MAX_FRAME_DIM);  // counters and frame dim - 1
  localparam int MW  = $clog2(MAX_MASK_DIM);   // matte index and matte dim - 1
  localparam int NW  = CW + MW;                // divider numerator / quotient
  localparam int BCW = $clog2(NW);
  localparam int MPW = 2 * MW + 1;             // row * width + column

  // ---------------------------------------------------------------- config regs
  logic [CW-1:0]  fw_m1_r, fh_m1_r;
  logic [MW-1:0]  mw_m1_r, mh_m1_r;
  logic           use_bg_r, mask_on_r;
  logic [23:0]    solid_r;
  logic           dim_wr;

  assign cfg_ready = 1'b1;
  assign dim_wr = cfg_valid && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT ||
                                cfg_index == REG_MASK_WIDTH  || cfg_index == REG_MASK_HEIGHT);

  // Dimensions are held as value minus one, already clamped to the supported range
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_m1_r   <= '0;
      fh_m1_r   <= '0;
      mw_m1_r   <= '0;
      mh_m1_r   <= '0;
      use_bg_r  <= 1'b0;
      solid_r   <= '0;
      mask_on_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  fw_m1_r <= CW'(dim_m1(cfg_data[FD_RW-1:0], MAX_FRAME_DIM));
        REG_FRAME_HEIGHT: fh_m1_r <= CW'(dim_m1(cfg_data[FD_RW-1:0], MAX_FRAME_DIM));
        REG_MASK_WIDTH:   mw_m1_r <= MW'(dim_m1(FD_RW'(cfg_data[MD_RW-1:0]), MAX_MASK_DIM));
        REG_MASK_HEIGHT:  mh_m1_r <= MW'(dim_m1(FD_RW'(cfg_data[MD_RW-1:0]), MAX_MASK_DIM));
        REG_USE_BG_IMAGE: use_bg_r <= cfg_data[0];
        REG_SOLID_COLOR:  solid_r <= cfg_data[23:0];
        REG_MASK_PRESENT: mask_on_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshakes
  logic adv, rc_busy, pix_acc, in_acc;

  assign adv       = !out_tvalid || out_tready;   // whole pipe moves together
  assign in_tready = adv && !rc_busy;
  assign in_acc    = in_tvalid && in_tready;
  assign pix_acc   = in_acc && in_tuser;

  // ---------------------------------------------------------------- position and steppers
  // xi/yi hold floor(pos*(mdim-1)/(fdim-1)), xr/yr the remainder;
  // qx/rx and qy/ry are the per-pixel increment as quotient and remainder.
  logic [CW-1:0]  col_r, row_r;
  logic [NW-1:0]  xi_r, yi_r;
  logic [CW-1:0]  xr_r, yr_r, rx_r, ry_r;
  logic [MW-1:0]  qx_r, qy_r;

  logic           last_col, last_row;
  logic [CW:0]    xs, ys;
  logic           xcarry, ycarry;
  logic [NW-1:0]  xi_adv, yi_adv;
  logic [CW-1:0]  xr_adv, yr_adv;

  assign last_col = col_r >= fw_m1_r;   // also catches a counter left past a shrunk frame
  assign last_row = row_r >= fh_m1_r;

  always_comb begin
    xs     = {1'b0, xr_r} + {1'b0, rx_r};
    xcarry = xs >= {1'b0, fw_m1_r};
    xi_adv = xi_r + NW'(qx_r) + NW'(xcarry);
    xr_adv = xcarry ? CW'(xs - {1'b0, fw_m1_r}) : xs[CW-1:0];
    ys     = {1'b0, yr_r} + {1'b0, ry_r};
    ycarry = ys >= {1'b0, fh_m1_r};
    yi_adv = yi_r + NW'(qy_r) + NW'(ycarry);
    yr_adv = ycarry ? CW'(ys - {1'b0, fh_m1_r}) : ys[CW-1:0];
  end

  // ---------------------------------------------------------------- recompute sequencer
  rc_state_t      rc_state_r, rc_state_nxt;
  rc_phase_t      rc_phase_r, rc_phase_inc;
  logic           pend_r;
  logic [BCW-1:0] bit_cnt_r;
  logic [NW-1:0]  dvd_r, dvd_new, num_sel, q_res;
  logic [CW:0]    rem_r, rem_sh, rem_new;
  logic [CW-1:0]  dsr, r_res;
  logic           ge, zero_div;
  logic           rc_load, rc_step, rc_last;

  assign rc_busy = pend_r || (rc_state_r != RC_IDLE);

  always_comb begin
    rc_state_nxt = rc_state_r;
    unique case (rc_state_r)
      RC_IDLE: if (pend_r) rc_state_nxt = RC_LOAD;
      RC_LOAD: rc_state_nxt = RC_DIV;
      RC_DIV: begin
        if (rc_last) rc_state_nxt = (rc_phase_r == PH_YSTEP) ? RC_IDLE : RC_LOAD;
      end
      default: rc_state_nxt = RC_IDLE;
    endcase
    if (dim_wr) rc_state_nxt = RC_IDLE;   // restart from the top on any new dimension
  end

  always_comb begin
    rc_load = rc_state_r == RC_LOAD;
    rc_step = rc_state_r == RC_DIV;
    rc_last = rc_step && (bit_cnt_r == BCW'(NW - 1));
  end

  always_comb begin
    unique case (rc_phase_r)
      PH_XPOS:  rc_phase_inc = PH_XSTEP;
      PH_XSTEP: rc_phase_inc = PH_YPOS;
      PH_YPOS:  rc_phase_inc = PH_YSTEP;
      PH_YSTEP: rc_phase_inc = PH_XPOS;
      default:  rc_phase_inc = PH_XPOS;
    endcase
  end

  always_comb begin
    unique case (rc_phase_r)
      PH_XPOS:  num_sel = NW'(col_r) * NW'(mw_m1_r);
      PH_XSTEP: num_sel = NW'(mw_m1_r);
      PH_YPOS:  num_sel = NW'(row_r) * NW'(mh_m1_r);
      PH_YSTEP: num_sel = NW'(mh_m1_r);
      default:  num_sel = '0;
    endcase
    dsr      = (rc_phase_r == PH_XPOS || rc_phase_r == PH_XSTEP) ? fw_m1_r : fh_m1_r;
    zero_div = dsr == '0;                       // one-pixel dimension samples index 0
    rem_sh   = {rem_r[CW-1:0], dvd_r[NW-1]};
    ge       = rem_sh >= {1'b0, dsr};
    rem_new  = ge ? rem_sh - {1'b0, dsr} : rem_sh;
    dvd_new  = {dvd_r[NW-2:0], ge};
    q_res    = zero_div ? '0 : dvd_new;
    r_res    = zero_div ? '0 : rem_new[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_state_r <= RC_IDLE;
      rc_phase_r <= PH_XPOS;
      pend_r     <= 1'b0;
      bit_cnt_r  <= '0;
    end else begin
      rc_state_r <= rc_state_nxt;
      if (dim_wr) begin
        pend_r <= 1'b1;
      end else if (rc_state_r == RC_IDLE) begin
        pend_r <= 1'b0;
      end
      if (rc_state_r == RC_IDLE) begin
        rc_phase_r <= PH_XPOS;
      end else if (rc_last) begin
        rc_phase_r <= rc_phase_inc;
      end
      if (rc_load) begin
        bit_cnt_r <= '0;
      end else if (rc_step) begin
        bit_cnt_r <= bit_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rc_load) begin
      dvd_r <= num_sel;
      rem_r <= '0;
    end else if (rc_step) begin
      dvd_r <= dvd_new;
      rem_r <= rem_new;
    end
  end

  // Position counters and stepper state; recompute and pixels never overlap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      xi_r  <= '0;
      yi_r  <= '0;
      xr_r  <= '0;
      yr_r  <= '0;
      qx_r  <= '0;
      qy_r  <= '0;
      rx_r  <= '0;
      ry_r  <= '0;
    end else if (rc_last) begin
      unique case (rc_phase_r)
        PH_XPOS:  begin xi_r <= q_res; xr_r <= r_res; end
        PH_XSTEP: begin qx_r <= q_res[MW-1:0]; rx_r <= r_res; end
        PH_YPOS:  begin yi_r <= q_res; yr_r <= r_res; end
        PH_YSTEP: begin qy_r <= q_res[MW-1:0]; ry_r <= r_res; end
        default: ;
      endcase
    end else if (pix_acc) begin
      if (last_col) begin
        col_r <= '0;
        xi_r  <= '0;
        xr_r  <= '0;
        if (last_row) begin
          row_r <= '0;
          yi_r  <= '0;
          yr_r  <= '0;
        end else begin
          row_r <= row_r + 1'b1;
          yi_r  <= yi_adv;
          yr_r  <= yr_adv;
        end
      end else begin
        col_r <= col_r + 1'b1;
        xi_r  <= xi_adv;
        xr_r  <= xr_adv;
      end
    end
  end

  // ---------------------------------------------------------------- matte store
  logic [MW-1:0]     xi_c, yi_c;
  logic [MPW-1:0]    samp_full;
  logic [MAT_AW-1:0] mat_addr;
  logic [7:0]        mat_mem [MAT_DEPTH];
  logic [7:0]        mat_q;

  always_comb begin
    xi_c      = (xi_r > NW'(mw_m1_r)) ? mw_m1_r : xi_r[MW-1:0];
    yi_c      = (yi_r > NW'(mh_m1_r)) ? mh_m1_r : yi_r[MW-1:0];
    samp_full = MPW'(yi_c) * (MPW'(mw_m1_r) + 1'b1) + MPW'(xi_c);
    mat_addr  = in_tuser ? MAT_AW'(samp_full) : in_tdata[15:0];
  end

  // One access per accepted word: a write for matte bytes, a read for pixels
  always_ff @(posedge clk) begin
    if (in_acc && !in_tuser) begin
      mat_mem[mat_addr] <= in_tdata[23:16];
    end
    if (pix_acc) begin
      mat_q <= mat_mem[mat_addr];
    end
  end

  // ---------------------------------------------------------------- blend pipe
  logic             s1_vld_r, s1_eof_r;
  logic [2:0][7:0]  s1_fg_r, s1_bg_r;
  logic             s2_vld_r, s2_eof_r;
  logic [2:0][15:0] s2_pfg_r, s2_pbg_r;
  logic [7:0]       alpha, alpha_inv;
  logic [2:0][15:0] blend_sum;
  logic             out_valid_r, out_tlast_r;
  logic [2:0][7:0]  out_tdata_r;

  assign alpha     = mask_on_r ? mat_q : 8'd0;
  assign alpha_inv = 8'd255 - alpha;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r    <= pix_acc;
      s2_vld_r    <= s1_vld_r;
      out_valid_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && pix_acc) begin
      s1_fg_r  <= in_tdata[47:24];
      s1_bg_r  <= use_bg_r ? in_tdata[71:48] : {solid_r[7:0], solid_r[15:8], solid_r[23:16]};
      s1_eof_r <= last_col && last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_vld_r) begin
      for (int i = 0; i < 3; i++) begin
        s2_pfg_r[i] <= 16'(s1_fg_r[i]) * 16'(alpha);
        s2_pbg_r[i] <= 16'(s1_bg_r[i]) * 16'(alpha_inv);
      end
      s2_eof_r <= s1_eof_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      blend_sum[i] = s2_pfg_r[i] + s2_pbg_r[i];   // at most 255*255
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_vld_r) begin
      for (int i = 0; i < 3; i++) begin
        out_tdata_r[i] <= div255(blend_sum[i]);
      end
      out_tlast_r <= s2_eof_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // ---------------------------------------------------------------- checks
  `MAC_ASSERT(a_col_rem_range, rc_busy || fw_m1_r == '0 || xr_r < fw_m1_r, "column stepper remainder out of range")
  `MAC_ASSERT(a_row_rem_range, rc_busy || fh_m1_r == '0 || yr_r < fh_m1_r, "row stepper remainder out of range")
  `MAC_ASSERT_NEXT(a_pix_enters, pix_acc, s1_vld_r, "accepted pixel did not enter the blend pipe")
  `MAC_ASSERT_NEXT(a_stall_holds, s2_vld_r && !adv, s2_vld_r, "blend stage lost a word under stall")

endmodule
